// ----- hdl/itrs_pkg.sv -----
// Shared types, constants and helper functions for the integer to radix string unit.
`timescale 1ns / 1ps

package itrs_pkg;

    // Field widths.
    localparam int VALUE_W    = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int OUT_DATA_W = 8;

    // Radix limits and the reset value of the radix register.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

    // Sizing defaults.
    localparam int MAX_DIGITS_DEF     = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS          = VALUE_W / DIV_BITS_PER_CYCLE;

    // One classified request waiting for digit extraction.
    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        logic [RADIX_W-1:0] radix;
    } t_item;

    // Request to the divider.
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    // Status and result of the divider.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [RADIX_W-1:0] remainder;
    } t_div_rsp;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } t_back_state;

    // Digit value to its ASCII character, 0-9 then A-Z.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] w;
        w = {1'b0, d};
        if (d < RADIX_DEC) begin
            return CHAR_ZERO + w;
        end
        return CHAR_A + w - {1'b0, RADIX_DEC};
    endfunction

endpackage

// ----- hdl/itrs_front.sv -----
// Front end: radix register, request acceptance and sign/magnitude classification.
`timescale 1ns / 1ps

module itrs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [itrs_pkg::RADIX_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [itrs_pkg::VALUE_W-1:0] i_s_axis_tdata,  // value[31:0]
    // Towards the queue.
    input  logic                         i_q_full,
    output logic                         o_push,
    output itrs_pkg::t_item              o_item
);

    logic [itrs_pkg::RADIX_W-1:0] r_radix;
    logic [itrs_pkg::RADIX_W-1:0] w_eff_radix;
    logic                         w_negative;

    // The radix register takes every write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itrs_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Out-of-range radix values are clamped to the nearest legal base.
    always_comb begin
        if (r_radix < itrs_pkg::RADIX_MIN) begin
            w_eff_radix = itrs_pkg::RADIX_MIN;
        end else if (r_radix > itrs_pkg::RADIX_MAX) begin
            w_eff_radix = itrs_pkg::RADIX_MAX;
        end else begin
            w_eff_radix = r_radix;
        end
    end

    // Only decimal output is signed; other bases see the raw bit pattern.
    assign w_negative = (w_eff_radix == itrs_pkg::RADIX_DEC) &&
                        i_s_axis_tdata[itrs_pkg::VALUE_W-1];

    assign o_item.negative  = w_negative;
    assign o_item.radix     = w_eff_radix;
    assign o_item.magnitude = w_negative ? (~i_s_axis_tdata + 1'b1) : i_s_axis_tdata;

    // A request is taken whenever the queue has room.
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

endmodule

// ----- hdl/itrs_queue.sv -----
// Short queue of classified requests between the front and back ends.
`timescale 1ns / 1ps

module itrs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  itrs_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output itrs_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int DEPTH = itrs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itrs_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/itrs_div.sv -----
// Iterative restoring divider of a 32-bit value by a small radix, two quotient bits a cycle.
`timescale 1ns / 1ps

module itrs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itrs_pkg::t_div_req i_req,
    output itrs_pkg::t_div_rsp o_rsp
);

    localparam int VW     = itrs_pkg::VALUE_W;
    localparam int RW     = itrs_pkg::RADIX_W;
    localparam int ITER_W = $clog2(itrs_pkg::DIV_STEPS);

    logic [VW-1:0]     r_q;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_div;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;
    logic [VW-1:0]     n_q;
    logic [RW-1:0]     n_rem;

    // Shift the dividend out at the top while quotient bits enter at the bottom.
    always_comb begin
        logic [RW:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < itrs_pkg::DIV_BITS_PER_CYCLE; i++) begin
            t   = {n_rem, n_q[VW-1]};
            n_q = {n_q[VW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem  = RW'(t - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = t[RW-1:0];
            end
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == ITER_W'(itrs_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- hdl/itrs_back.sv -----
// Back end: digit extraction sequencer, digit store and character output register.
`timescale 1ns / 1ps

module itrs_back #(
    parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // From the queue.
    input  logic                            i_q_valid,
    input  itrs_pkg::t_item                 i_q_item,
    output logic                            o_q_pop,
    // Divider.
    output itrs_pkg::t_div_req              o_div_req,
    input  itrs_pkg::t_div_rsp              i_div_rsp,
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itrs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // char_code[6:0], zero[7]
    output logic                            o_m_axis_tlast   // last
);

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    localparam int RW = itrs_pkg::RADIX_W;
    localparam int CW = itrs_pkg::CHAR_W;

    itrs_pkg::t_back_state r_state, n_state;
    logic                  r_neg, n_neg;
    logic [RW-1:0]         r_radix, n_radix;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;
    logic                  r_out_valid, n_out_valid;
    logic [CW-1:0]         r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;
    logic                  w_wr_en;
    logic                  w_slot_free;

    logic [RW-1:0]         r_mem [MAX_DIGITS];
    logic [RW-1:0]         r_rd_data;

    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    // State register and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itrs_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_neg       <= n_neg;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_radix    <= n_radix;
        r_ptr      <= n_ptr;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Digit store, least significant digit at address zero.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_div_rsp.remainder;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    // Next state and outputs.
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_radix     = r_radix;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_wr_en     = 1'b0;
        o_q_pop     = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_div_rsp.quotient;
        o_div_req.divisor  = r_radix;

        case (r_state)
            // Take the next request and start the first division.
            itrs_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop            = 1'b1;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = i_q_item.magnitude;
                    o_div_req.divisor  = i_q_item.radix;
                    n_neg              = i_q_item.negative;
                    n_radix            = i_q_item.radix;
                    n_count            = '0;
                    n_state            = itrs_pkg::BK_DIV;
                end
            end
            // Store each remainder; divide the quotient again until it is zero or the store fills.
            itrs_pkg::BK_DIV: begin
                if (i_div_rsp.done) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    if ((i_div_rsp.quotient == '0) || (n_count == MAX_CNT)) begin
                        n_ptr   = r_count[ADDR_W-1:0];
                        n_state = r_neg ? itrs_pkg::BK_SIGN : itrs_pkg::BK_READ;
                    end else begin
                        o_div_req.start = 1'b1;
                    end
                end
            end
            // Leading minus sign for a negative decimal value.
            itrs_pkg::BK_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itrs_pkg::CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = itrs_pkg::BK_READ;
                end
            end
            // Wait state for the registered store read.
            itrs_pkg::BK_READ: begin
                n_state = itrs_pkg::BK_EMIT;
            end
            // Emit digits from the most significant one down.
            itrs_pkg::BK_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itrs_pkg::digit_char(r_rd_data);
                    n_out_last  = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = itrs_pkg::BK_IDLE;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        n_state = itrs_pkg::BK_READ;
                    end
                end
            end
            default: begin
                n_state = itrs_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(itrs_pkg::OUT_DATA_W - CW){1'b0}}, r_out_char};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- hdl/integer_to_radix_string_unit.sv -----
// Top level of the integer to radix string unit.
`timescale 1ns / 1ps

// Converts one 32-bit integer per input request into its text form, one ASCII
// character per output request, most significant digit first, digits 0-9 then A-Z.
// The radix (2 to 36, clamped outside that range) is written on the cfg channel,
// which is always ready; write it only while the unit is idle. In radix ten a
// negative value is written as a minus sign and its magnitude, otherwise the raw
// unsigned pattern is converted. tlast marks the final character of each number.
// The front end classifies an accepted request in the same cycle and places it in
// a two-entry queue, so up to two further requests are taken while one is worked.
// The back end produces the digits one at a time with the divider, which
// retires two quotient bits a cycle, then emits the characters from the digit
// store, with a store read state before each digit. A stalled receiver
// holds the output register; the sequencer waits with it and the queue fills
// before the input stalls. Synchronous active-low reset empties the queue,
// idles the sequencer and sets the radix to ten. The digit store has no reset
// and needs no clearing pass.

module integer_to_radix_string_unit #(
    parameter int MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itrs_pkg::RADIX_W-1:0]    i_cfg_data,      // radix[5:0]
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [itrs_pkg::VALUE_W-1:0]    i_s_axis_tdata,  // value[31:0]
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itrs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // char_code[6:0], zero[7]
    output logic                            o_m_axis_tlast   // last
);

    logic               w_push;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_q_pop;
    itrs_pkg::t_item    w_front_item;
    itrs_pkg::t_item    w_q_item;
    itrs_pkg::t_div_req w_div_req;
    itrs_pkg::t_div_rsp w_div_rsp;

    // Request acceptance and classification.
    itrs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    // Decoupling queue.
    itrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // Radix divider.
    itrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Digit extraction and character output.
    itrs_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_div_req       (w_div_req),
        .i_div_rsp       (w_div_rsp),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // The front end never pushes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("request pushed into a full queue");

    // A division is never started while the previous one is still running.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // Every finished division leaves a digit that fits the largest radix.
    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (w_div_rsp.remainder < itrs_pkg::RADIX_MAX))
        else $error("divider remainder out of digit range");

    // A request is popped only when the queue holds one.
    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from an empty queue");

endmodule

// ----- tb/integer_to_radix_string_unit_test.sv -----
// Self-checking testbench for the integer to radix string unit.
`timescale 1ns / 1ps

module integer_to_radix_string_unit_test;

    // Slowest correct run: about 400 numbers of 32 binary digits each, plus receiver
    // stalls and sender gaps; the limit is several times that.
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 350;
    localparam int PHASES        = 3;
    localparam int SEGMENTS      = 4;

    // One expected output character.
    typedef struct packed {
        logic [itrs_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    // Kinds of row in the directed table.
    typedef enum logic {
        ROW_RADIX,
        ROW_VALUE
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] data;
        string       text;
    } t_row;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic                            o_cfg_ready;
    logic [itrs_pkg::RADIX_W-1:0]    i_cfg_data      = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [itrs_pkg::VALUE_W-1:0]    i_s_axis_tdata  = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [itrs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tlast;

    // Testbench state.
    t_text_char                   awaited_chars[$];
    t_row                         directed_rows[$];
    logic [itrs_pkg::RADIX_W-1:0] radix_setting   = itrs_pkg::RADIX_RESET;
    logic [63:0]                  radices_seen    = '0;
    string                        digit_set       = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    int                           sender_idle_pct = 0;
    int                           recv_idle_pct   = 0;
    int                           error_count     = 0;
    int                           numbers_sent    = 0;
    int                           chars_checked   = 0;
    int                           cycle_count     = 0;
    t_text_char                   got_char;
    t_text_char                   want_char;

    integer_to_radix_string_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // value[31:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // char_code[6:0], zero[7]
        .o_m_axis_tlast  (o_m_axis_tlast)    // last
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = ~i_clk;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure, idle for the current share of cycles.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted character against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_char = '{o_m_axis_tdata[itrs_pkg::CHAR_W-1:0], o_m_axis_tlast};
            if (awaited_chars.size() == 0) begin
                $error("char_code %h with last %b arrived with nothing expected",
                       got_char.code, got_char.last);
                error_count++;
            end else begin
                want_char = awaited_chars.pop_front();
                chars_checked++;
                if (got_char.code !== want_char.code) begin
                    $error("char_code: expected %h, got %h", want_char.code, got_char.code);
                    error_count++;
                end
                if (got_char.last !== want_char.last) begin
                    $error("last: expected %b, got %b", want_char.last, got_char.last);
                    error_count++;
                end
                if (o_m_axis_tdata[itrs_pkg::OUT_DATA_W-1] !== 1'b0) begin
                    $error("pad: expected 0, got %b", o_m_axis_tdata[itrs_pkg::OUT_DATA_W-1]);
                    error_count++;
                end
            end
        end
    end

    // Work out the characters of one number in the current radix, most significant first.
    function automatic void predict_text(input logic [31:0] value);
        logic [5:0]  base;
        logic [31:0] magnitude;
        logic        negative;
        logic [5:0]  digits[$];
        byte         ch;
        base = radix_setting;
        if (base < itrs_pkg::RADIX_MIN) begin
            base = itrs_pkg::RADIX_MIN;
        end else if (base > itrs_pkg::RADIX_MAX) begin
            base = itrs_pkg::RADIX_MAX;
        end
        negative  = (base == itrs_pkg::RADIX_DEC) && value[31];
        magnitude = negative ? (32'd0 - value) : value;
        do begin
            digits.push_back(6'(magnitude % base));
            magnitude = magnitude / base;
        end while (magnitude != 0);
        if (negative) begin
            awaited_chars.push_back('{itrs_pkg::CHAR_MINUS, 1'b0});
        end
        for (int k = digits.size() - 1; k >= 0; k--) begin
            ch = digit_set[digits[k]];
            awaited_chars.push_back('{ch[itrs_pkg::CHAR_W-1:0], k == 0});
        end
    endfunction

    // Queue a string typed in by hand as the expected text.
    function automatic void expect_text(input string text);
        byte ch;
        for (int k = 0; k < text.len(); k++) begin
            ch = text[k];
            awaited_chars.push_back('{ch[itrs_pkg::CHAR_W-1:0], k == text.len() - 1});
        end
    endfunction

    // Offer one number, with an occasional gap before it, and wait until it is taken.
    task automatic send_value(input logic [31:0] value, input string text);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (text.len() != 0) begin
            expect_text(text);
        end else begin
            predict_text(value);
        end
        numbers_sent++;
    endtask

    // Stop offering and wait until every expected character has come.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (awaited_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Change the radix while the unit is idle.
    task automatic write_radix(input logic [itrs_pkg::RADIX_W-1:0] radix);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= radix;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        radix_setting  = radix;
        radices_seen[radix] = 1'b1;
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [31:0] data,
                                    input string text);
        t_row row;
        row.kind = kind;
        row.data = data;
        row.text = text;
        directed_rows.push_back(row);
    endfunction

    // Random number: full range, small positive, small negative or an extreme.
    function automatic logic [31:0] pick_value();
        logic [31:0] extremes[5];
        extremes = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF};
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 1000);
            2: return 32'd0 - $urandom_range(1, 1000);
            default: return extremes[$urandom_range(4)];
        endcase
    endfunction

    // Mostly legal radices, sometimes a code outside two to thirty-six.
    function automatic logic [itrs_pkg::RADIX_W-1:0] pick_radix();
        if ($urandom_range(9) == 0) begin
            return ($urandom_range(1) != 0) ? 6'($urandom_range(0, 1))
                                            : 6'($urandom_range(37, 63));
        end
        return 6'($urandom_range(2, 36));
    endfunction

    initial begin
        int per_segment;
        per_segment = RANDOM_ITEMS / (PHASES * SEGMENTS);

        // Directed table: decimal after reset, then every clamp and the extremes.
        add_row(ROW_VALUE, 32'd0,         "0");
        add_row(ROW_VALUE, 32'd1,         "1");
        add_row(ROW_VALUE, 32'h7FFF_FFFF, "2147483647");
        add_row(ROW_VALUE, 32'h8000_0000, "-2147483648");
        add_row(ROW_VALUE, 32'hFFFF_FFFF, "-1");
        add_row(ROW_RADIX, 32'd2,         "");
        add_row(ROW_VALUE, 32'hFFFF_FFFF, {"11111111", "11111111", "11111111", "11111111"});
        add_row(ROW_VALUE, 32'd0,         "0");
        add_row(ROW_VALUE, 32'h8000_0000, {"10000000", "00000000", "00000000", "00000000"});
        add_row(ROW_RADIX, 32'd16,        "");
        add_row(ROW_VALUE, 32'hDEAD_BEEF, "DEADBEEF");
        add_row(ROW_VALUE, 32'hFFFF_FFFF, "FFFFFFFF");
        add_row(ROW_RADIX, 32'd36,        "");
        add_row(ROW_VALUE, 32'hFFFF_FFFF, "");
        add_row(ROW_VALUE, 32'd1295,      "ZZ");
        add_row(ROW_RADIX, 32'd0,         "");
        add_row(ROW_VALUE, 32'd5,         "101");
        add_row(ROW_RADIX, 32'd1,         "");
        add_row(ROW_VALUE, 32'd6,         "110");
        add_row(ROW_RADIX, 32'd37,        "");
        add_row(ROW_VALUE, 32'd35,        "Z");
        add_row(ROW_RADIX, 32'd63,        "");
        add_row(ROW_VALUE, 32'd36,        "10");
        add_row(ROW_RADIX, 32'd8,         "");
        add_row(ROW_VALUE, 32'hFFFF_FFF8, "");
        add_row(ROW_RADIX, 32'd3,         "");
        add_row(ROW_VALUE, $urandom,      "");
        add_row(ROW_RADIX, 32'd10,        "");
        add_row(ROW_VALUE, 32'd12345,     "12345");
        add_row(ROW_VALUE, 32'hFFFF_FFF9, "-7");

        // Hold reset, then release it.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        radices_seen[itrs_pkg::RADIX_RESET] = 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 11;
        recv_idle_pct   = 50;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_RADIX) begin
                write_radix(directed_rows[r].data[itrs_pkg::RADIX_W-1:0]);
            end else begin
                send_value(directed_rows[r].data, directed_rows[r].text);
            end
        end

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int p = 0; p < PHASES; p++) begin
            sender_idle_pct = (p == 0) ? 11 : (p == 1) ? 50 : 0;
            recv_idle_pct   = (p == 0) ? 50 : (p == 1) ? 11 : 0;
            for (int s = 0; s < SEGMENTS; s++) begin
                // Each phase opens in decimal so that negatives are written out.
                write_radix((s == 0) ? itrs_pkg::RADIX_DEC : pick_radix());
                for (int i = 0; i < per_segment; i++) begin
                    if (p == 0 && s == 1 && i == per_segment / 2) begin
                        wait_drained();
                    end
                    send_value(pick_value(), "");
                end
            end
        end

        wait_drained();

        $display("Converted %0d numbers into %0d checked characters over %0d radix codes,",
                 numbers_sent, chars_checked, $countones(radices_seen));
        $display("with codes below two and above thirty-six and three idling patterns.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
